// ===== sv/esm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esm_pkg: shared types and constants for the encoder speed measurement
// Item and result records passed between the top level and the core, and
// register map codes for the configuration port.
// ----------------------------------------------------------------------------
package esm_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned SPD_W   = 31;
  localparam int unsigned PROD_W  = POS_W + SCALE_W;
  localparam int unsigned ADD_W   = PROD_W + 1;

  localparam logic [SPD_W-1:0]   SPEED_MAX       = 31'h7FFF_FFFF;
  localparam logic [PER_W-1:0]   OVERFLOW_PERIOD = 16'hFFFF;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 10'd25;
  localparam logic [31:0]        NUMER_RESET     = 32'd2343750;

  // register index, taken from paddr[2]
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_NUMER = 1'b1;

  typedef struct packed {
    logic             unit_timeout;
    logic [POS_W-1:0] latched_position;
    logic             count_up;
    logic             unit_position_event;
    logic             capture_overflow;
    logic [PER_W-1:0] capture_period;
  } esm_item_t;

  typedef struct packed {
    logic [SPD_W-1:0] position_speed;
    logic             position_speed_valid;
    logic [31:0]      period_speed;
    logic             period_speed_valid;
    logic             zero_period_error;
  } esm_result_t;

endpackage
`default_nettype wire

// ===== sv/esm_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esm_core: sequenced datapath for one encoder event
// A single add/subtract unit forms the position delta, the shift-add
// product with the scale and the restoring divide of the numerator.
// ----------------------------------------------------------------------------
module esm_core
  import esm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire esm_item_t           item,
  input  wire logic [SCALE_W-1:0]  scale,
  input  wire logic [31:0]         numer,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output esm_result_t              res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [POS_W-1:0]  prev_r, prev_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  delta_r, delta_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PER_W-1:0]  per_r, per_nxt;
  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [31:0]       q_r, q_nxt;
  logic              tmo_r, tmo_nxt;
  logic              up_r, up_nxt;
  logic              evt_r, evt_nxt;

  logic [ADD_W-1:0]  add_a, add_b;
  logic              add_sub;
  logic [ADD_W:0]    add_sum;
  logic [PER_W-1:0]  per_in;
  logic              div_go;

  // shared adder; carry out of a subtract means no borrow
  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {ADD_W{add_sub}}}
                 + {{ADD_W{1'b0}}, add_sub};

  assign per_in = item.capture_overflow ? OVERFLOW_PERIOD : item.capture_period;
  assign div_go = evt_r && (per_r != '0);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_DELTA: begin
        add_sub = 1'b1;
        add_a   = {{(ADD_W-POS_W){1'b0}}, up_r ? pos_r : prev_r};
        add_b   = {{(ADD_W-POS_W){1'b0}}, up_r ? prev_r : pos_r};
      end
      S_MUL: begin
        add_a = {acc_r, 1'b0};
        add_b = scale[cnt_r[3:0]] ? {{(ADD_W-POS_W){1'b0}}, delta_r} : '0;
      end
      S_DIV: begin
        add_sub = 1'b1;
        add_a   = {{(ADD_W-PER_W-1){1'b0}}, rem_r, q_r[31]};
        add_b   = {{(ADD_W-PER_W){1'b0}}, per_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    pos_nxt   = pos_r;
    delta_nxt = delta_r;
    acc_nxt   = acc_r;
    per_nxt   = per_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    tmo_nxt   = tmo_r;
    up_nxt    = up_r;
    evt_nxt   = evt_r;
    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          tmo_nxt = item.unit_timeout;
          pos_nxt = item.latched_position;
          up_nxt  = item.count_up;
          evt_nxt = item.unit_position_event;
          per_nxt = per_in;
          q_nxt   = numer;
          rem_nxt = '0;
          acc_nxt = '0;
          if (item.unit_timeout) begin
            state_nxt = S_DELTA;
          end else if (item.unit_position_event && (per_in != '0)) begin
            state_nxt = S_DIV;
            cnt_nxt   = 5'd31;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DELTA: begin
        delta_nxt = add_sum[POS_W-1:0];
        prev_nxt  = pos_r;
        cnt_nxt   = 5'(SCALE_W - 1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // msb-first shift and add over the scale bits
        acc_nxt = add_sum[PROD_W-1:0];
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          if (div_go) begin
            state_nxt = S_DIV;
            cnt_nxt   = 5'd31;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (add_sum[ADD_W]) begin
          rem_nxt = add_sum[PER_W-1:0];
        end else begin
          rem_nxt = {rem_r[PER_W-2:0], q_r[31]};
        end
        q_nxt   = {q_r[30:0], add_sum[ADD_W]};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    delta_r <= delta_nxt;
    acc_r   <= acc_nxt;
    per_r   <= per_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    tmo_r   <= tmo_nxt;
    up_r    <= up_nxt;
    evt_r   <= evt_nxt;
  end

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);

  always_comb begin
    res.position_speed       = '0;
    if (tmo_r) begin
      res.position_speed = (|acc_r[PROD_W-1:SPD_W]) ? SPEED_MAX : acc_r[SPD_W-1:0];
    end
    res.position_speed_valid = tmo_r;
    res.period_speed         = div_go ? q_r : '0;
    res.period_speed_valid   = evt_r;
    res.zero_period_error    = evt_r && (per_r == '0);
  end

  a_busy_while_result : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !item_ready)
    else $error("core ready while a result is pending");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && item_ready) |=> !item_ready)
    else $error("core took a second transfer without finishing");

  a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < per_r))
    else $error("divide remainder not below period");

  a_mul_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < 5'(SCALE_W)))
    else $error("multiply count out of range");

  a_zero_err_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.zero_period_error) |-> (res.period_speed == '0))
    else $error("zero period gave a nonzero speed");

endmodule
`default_nettype wire

// ===== sv/encoder_speed_measurement.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_measurement: fast and slow speed from encoder events
//
//   channel  direction  handshake                      contents
//   in_      input      in_valid / in_ready            one encoder event
//   out_     output     out_valid / out_ready          speeds and flags
//   apb      input      psel penable pwrite pready     scale, numerator
//
// An event with no work goes straight to its result; a unit timeout adds the
// delta and ten shift-add steps, a period divide adds 32 restoring steps, and
// both run all of them; all steps share one 43-bit add/subtract unit.
// Reset sets the registers to scale 25 and numerator 2343750 and clears the
// stored position. A finished result sits in the output register, so the
// core is free for the next event while out_ready is low; the core waits only
// if a second result is done before the first transfer.
// ----------------------------------------------------------------------------
module encoder_speed_measurement
  import esm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_unit_timeout,
  input  wire logic [31:0]  in_latched_position,
  input  wire logic         in_count_up,
  input  wire logic         in_unit_position_event,
  input  wire logic         in_capture_overflow,
  input  wire logic [15:0]  in_capture_period,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [30:0]       out_position_speed,
  output logic              out_position_speed_valid,
  output logic [31:0]       out_period_speed,
  output logic              out_period_speed_valid,
  output logic              out_zero_period_error,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [SCALE_W-1:0] scale_r;
  logic [31:0]        numer_r;
  logic               out_valid_r, out_valid_nxt;
  esm_result_t        out_r;
  esm_item_t          item;
  esm_result_t        res;
  logic               res_valid, res_ready;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      numer_r <= NUMER_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SCALE: scale_r <= pwdata[SCALE_W-1:0];
        REG_NUMER: numer_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCALE: prdata = {{(32-SCALE_W){1'b0}}, scale_r};
      REG_NUMER: prdata = numer_r;
      default:   prdata = '0;
    endcase
  end

  assign item.unit_timeout        = in_unit_timeout;
  assign item.latched_position    = in_latched_position;
  assign item.count_up            = in_count_up;
  assign item.unit_position_event = in_unit_position_event;
  assign item.capture_overflow    = in_capture_overflow;
  assign item.capture_period      = in_capture_period;

  esm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (item),
    .scale      (scale_r),
    .numer      (numer_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output slot loads when empty or emptied by this transfer
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_position_speed       = out_r.position_speed;
  assign out_position_speed_valid = out_r.position_speed_valid;
  assign out_period_speed         = out_r.period_speed;
  assign out_period_speed_valid   = out_r.period_speed_valid;
  assign out_zero_period_error    = out_r.zero_period_error;

  a_hold_when_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result changed before its transfer");

  a_flag_needs_event : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.zero_period_error || out_r.period_speed_valid))
    else $error("zero period flag without a position event");

  a_idle_speed_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.position_speed_valid) |-> (out_r.position_speed == '0))
    else $error("position speed without a timeout");

endmodule
`default_nettype wire
